@@ rtl/core/mmrl_pkg.sv @@
// Shared types, constants and helper functions of the mecanum mixer and ramp limiter.
package mmrl_pkg;

  // Wheel count and index width
  localparam int WHEELS      = 4;
  localparam int WHEEL_IDX_W = $clog2(WHEELS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_JOYSTICK_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME_MS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD_MS = 3'd6;

  // Register reset values
  localparam logic [6:0]  RST_JOYSTICK_LIMIT    = 7'd100;
  localparam logic [5:0]  RST_TRANSLATION_SCALE = 6'd7;
  localparam logic [5:0]  RST_ROTATION_SCALE    = 6'd7;
  localparam logic [14:0] RST_AXIS_LIMIT        = 15'd700;
  localparam logic [14:0] RST_SPEED_LIMIT       = 15'd1600;
  localparam logic [11:0] RST_RAMP_TIME_MS      = 12'd1000;
  localparam logic [7:0]  RST_CONTROL_PERIOD_MS = 8'd10;

  // Millisecond counter saturates at all ones
  localparam int            MS_W   = 12;
  localparam logic [MS_W-1:0] MS_MAX = '1;

  // Serial divider: dividend and divisor widths
  localparam int DIV_W = 30;
  localparam int DVS_W = 15;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Ramp step never exceeds speed limit plus a stale remainder
  localparam int STEP_W = 17;

  typedef logic signed [15:0] wheel_t;
  typedef logic signed [7:0]  axis_t;

  typedef struct packed {
    logic [6:0]  joystick_limit;
    logic [5:0]  translation_scale;
    logic [5:0]  rotation_scale;
    logic [14:0] axis_limit;
    logic [14:0] speed_limit;
    logic [11:0] ramp_time_ms;
    logic [7:0]  control_period_ms;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // Symmetric clamp of one stick axis
  function automatic axis_t clamp_axis(input logic signed [15:0] v, input logic [6:0] lim);
    logic signed [16:0] ve;
    logic signed [16:0] pl;
    logic signed [16:0] nl;
    logic signed [16:0] r;
    ve = {v[15], v};
    pl = $signed({10'd0, lim});
    nl = -pl;
    if (ve > pl) r = pl;
    else if (ve < nl) r = nl;
    else r = ve;
    return r[7:0];
  endfunction

  // Magnitude of a mixed wheel value (always below 2^15)
  function automatic logic [14:0] abs_mag(input wheel_t v);
    wheel_t a;
    a = v[15] ? -v : v;
    return a[14:0];
  endfunction

  // One slew step of a ramped target toward its goal
  function automatic wheel_t move_toward(input wheel_t cur, input wheel_t goal,
                                         input logic [STEP_W-1:0] step);
    logic signed [17:0] d;
    logic signed [17:0] s;
    logic signed [17:0] ns;
    logic signed [17:0] r;
    d  = {{2{goal[15]}}, goal} - {{2{cur[15]}}, cur};
    s  = $signed({1'b0, step});
    ns = -s;
    if (d > s) r = {{2{cur[15]}}, cur} + s;
    else if (d < ns) r = {{2{cur[15]}}, cur} - s;
    else r = {{2{goal[15]}}, goal};
    return r[15:0];
  endfunction

endpackage

@@ rtl/core/mmrl_if.sv @@
// Channel interfaces: stick/tick input, wheel result and configuration write.
interface mmrl_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] left_x;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;

  modport source (output valid, cmd, left_x, right_x, right_y, input ready);
  modport sink   (input valid, cmd, left_x, right_x, right_y, output ready);
endinterface

interface mmrl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_a;
  logic signed [15:0] wheel_b;
  logic signed [15:0] wheel_c;
  logic signed [15:0] wheel_d;
  logic               stepped;
  logic               stopped;

  modport source (output valid, wheel_a, wheel_b, wheel_c, wheel_d, stepped, stopped,
                  input ready);
  modport sink   (input valid, wheel_a, wheel_b, wheel_c, wheel_d, stepped, stopped,
                  output ready);
endinterface

interface mmrl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mmrl_pkg::CFG_IDX_W-1:0]     index;
  logic [mmrl_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/mmrl_cfg.sv @@
// Configuration register file written over the configuration channel.
module mmrl_cfg (
  input  logic              clk,
  input  logic              rst,
  mmrl_cfg_if.sink          cfg,
  output mmrl_pkg::cfg_t    regs
);

  // Always able to take a write beat
  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.joystick_limit    <= mmrl_pkg::RST_JOYSTICK_LIMIT;
      regs.translation_scale <= mmrl_pkg::RST_TRANSLATION_SCALE;
      regs.rotation_scale    <= mmrl_pkg::RST_ROTATION_SCALE;
      regs.axis_limit        <= mmrl_pkg::RST_AXIS_LIMIT;
      regs.speed_limit       <= mmrl_pkg::RST_SPEED_LIMIT;
      regs.ramp_time_ms      <= mmrl_pkg::RST_RAMP_TIME_MS;
      regs.control_period_ms <= mmrl_pkg::RST_CONTROL_PERIOD_MS;
    end else if (cfg.valid) begin
      case (cfg.index)
        mmrl_pkg::REG_JOYSTICK_LIMIT:    regs.joystick_limit    <= cfg.data[6:0];
        mmrl_pkg::REG_TRANSLATION_SCALE: regs.translation_scale <= cfg.data[5:0];
        mmrl_pkg::REG_ROTATION_SCALE:    regs.rotation_scale    <= cfg.data[5:0];
        mmrl_pkg::REG_AXIS_LIMIT:        regs.axis_limit        <= cfg.data[14:0];
        mmrl_pkg::REG_SPEED_LIMIT:       regs.speed_limit       <= cfg.data[14:0];
        mmrl_pkg::REG_RAMP_TIME_MS:      regs.ramp_time_ms      <= cfg.data[11:0];
        mmrl_pkg::REG_CONTROL_PERIOD_MS: regs.control_period_ms <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/mmrl_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module mmrl_div (
  input  logic                clk,
  input  logic                rst,
  input  mmrl_pkg::div_req_t  req,
  output mmrl_pkg::div_rsp_t  rsp
);

  logic                              busy;
  logic                              done;
  logic [mmrl_pkg::DIV_CNT_W-1:0]    cnt;
  logic [mmrl_pkg::DVS_W-1:0]        rem;
  logic [mmrl_pkg::DIV_W-1:0]        quo;
  logic [mmrl_pkg::DVS_W-1:0]        dvs;

  logic [mmrl_pkg::DVS_W:0]          shifted;
  logic [mmrl_pkg::DVS_W:0]          trial;
  logic                              ge;
  logic [mmrl_pkg::DVS_W-1:0]        rem_next;

  // One trial subtraction
  always_comb begin
    shifted  = {rem, quo[mmrl_pkg::DIV_W-1]};
    trial    = shifted - {1'b0, dvs};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? trial[mmrl_pkg::DVS_W-1:0] : shifted[mmrl_pkg::DVS_W-1:0];
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == mmrl_pkg::DIV_CNT_W'(mmrl_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[mmrl_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ rtl/core/mecanum_mixer_ramp_limiter.sv @@
// Top level: sequencer and datapath of the mecanum mixer with ramp limiter.
//
// Channels: item (sink) takes either a stick command (cmd 0, three axes) or a
// one-millisecond tick (cmd 1). result (source) gives one beat per item: the
// four ramped wheel targets plus stepped and stopped flags. cfg (sink) writes
// the seven registers; it is always ready and must only be used while idle.
//
// One item at a time; item.ready is high only while the sequencer is idle.
// A command runs mix, normalise, then four wheel passes (product, start, the
// 30-bit quotient of the shared divider, collect) and a stop check before its
// result is loaded. A tick that updates the ramp checks its period, forms the
// ramp numerator and divides it once on the shared divider; a tick without an
// update goes from the check straight to loading its result.
//
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the following item finishes its work and
// holds in the final state until the register frees up.
//
// Reset (rst, synchronous) restores register defaults, clears goals, ramped
// targets, remainder, the millisecond count and the command-seen flag.
module mecanum_mixer_ramp_limiter (
  input  logic        clk,
  input  logic        rst,
  mmrl_cfg_if.sink    cfg,
  mmrl_in_if.sink     item,
  mmrl_out_if.source  result
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MIX    = 4'd1;
  localparam logic [3:0] ST_NORM   = 4'd2;
  localparam logic [3:0] ST_WMUL   = 4'd3;
  localparam logic [3:0] ST_WSTART = 4'd4;
  localparam logic [3:0] ST_WDIV   = 4'd5;
  localparam logic [3:0] ST_CDONE  = 4'd6;
  localparam logic [3:0] ST_TCHK   = 4'd7;
  localparam logic [3:0] ST_TMUL   = 4'd8;
  localparam logic [3:0] ST_TSTART = 4'd9;
  localparam logic [3:0] ST_TDIV   = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;

  mmrl_pkg::cfg_t      regs;
  mmrl_pkg::div_req_t  div_req;
  mmrl_pkg::div_rsp_t  div_rsp;

  logic [3:0]                          state;
  logic [mmrl_pkg::WHEEL_IDX_W-1:0]    idx;

  // Model state
  mmrl_pkg::wheel_t                    goal   [mmrl_pkg::WHEELS];
  mmrl_pkg::wheel_t                    ramped [mmrl_pkg::WHEELS];
  logic [11:0]                         ramp_rem;
  logic                                seen;
  logic [mmrl_pkg::MS_W-1:0]           ms;

  // Working registers
  mmrl_pkg::axis_t                     ax_lx;
  mmrl_pkg::axis_t                     ax_rx;
  mmrl_pkg::axis_t                     ax_ry;
  mmrl_pkg::wheel_t                    raw [mmrl_pkg::WHEELS];
  logic [14:0]                         norm;
  logic [mmrl_pkg::DIV_W-1:0]          prod;
  logic                                neg;
  logic                                nonzero;
  logic                                stepped_r;
  logic                                stopped_r;

  // Result register
  logic                                res_valid;
  mmrl_pkg::wheel_t                    res_wheel [mmrl_pkg::WHEELS];
  logic                                res_stepped;
  logic                                res_stopped;

  logic                                item_acc;
  logic                                res_load;

  // Mixing terms
  logic signed [13:0]                  ts_s;
  logic signed [13:0]                  rs_s;
  logic signed [13:0]                  vx;
  logic signed [13:0]                  vy;
  logic signed [13:0]                  om;
  logic signed [15:0]                  vx16;
  logic signed [15:0]                  vy16;
  logic signed [15:0]                  om16;

  // Normalisation and ramp terms
  logic [14:0]                         norm_c;
  logic [14:0]                         mag;
  logic [11:0]                         rt_c;
  logic [11:0]                         elapsed;
  logic [14:0]                         goal_q;
  logic [mmrl_pkg::STEP_W-1:0]         step;

  mmrl_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mmrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item.ready = (state == ST_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign res_load   = (state == ST_FIN) && (!res_valid || result.ready);

  // Stick scaling and wheel mixing
  always_comb begin
    ts_s = $signed({8'd0, regs.translation_scale});
    rs_s = $signed({8'd0, regs.rotation_scale});
    vx   = $signed({{6{ax_ry[7]}}, ax_ry}) * ts_s;
    vy   = -($signed({{6{ax_rx[7]}}, ax_rx}) * ts_s);
    om   = $signed({{6{ax_lx[7]}}, ax_lx}) * rs_s;
    vx16 = {{2{vx[13]}}, vx};
    vy16 = {{2{vy[13]}}, vy};
    om16 = {{2{om[13]}}, om};
  end

  // Largest magnitude, at least the axis limit
  always_comb begin
    norm_c = (regs.axis_limit == '0) ? 15'd1 : regs.axis_limit;
    for (int i = 0; i < mmrl_pkg::WHEELS; i++) begin
      if (mmrl_pkg::abs_mag(raw[i]) > norm_c) norm_c = mmrl_pkg::abs_mag(raw[i]);
    end
  end

  // Ramp time, capped elapsed time and division results
  always_comb begin
    mag     = mmrl_pkg::abs_mag(raw[idx]);
    rt_c    = (regs.ramp_time_ms == '0) ? 12'd1 : regs.ramp_time_ms;
    elapsed = (ms > rt_c) ? rt_c : ms;
    goal_q  = div_rsp.quotient[14:0];
    step    = div_rsp.quotient[mmrl_pkg::STEP_W-1:0];
  end

  // Divider request: wheel normalisation or ramp numerator
  always_comb begin
    div_req.start = (state == ST_WSTART) || (state == ST_TSTART);
    if (state == ST_TSTART) begin
      div_req.dividend = prod + {{(mmrl_pkg::DIV_W-12){1'b0}}, ramp_rem};
      div_req.divisor  = {{(mmrl_pkg::DVS_W-12){1'b0}}, rt_c};
    end else begin
      div_req.dividend = prod;
      div_req.divisor  = norm;
    end
  end

  // Sequencer and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      ramp_rem <= '0;
      seen     <= 1'b0;
      ms       <= '0;
      for (int i = 0; i < mmrl_pkg::WHEELS; i++) begin
        goal[i]   <= '0;
        ramped[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_acc) begin
            stepped_r <= 1'b0;
            stopped_r <= 1'b0;
            if (!item.cmd) begin
              ax_lx <= mmrl_pkg::clamp_axis(item.left_x,  regs.joystick_limit);
              ax_rx <= mmrl_pkg::clamp_axis(item.right_x, regs.joystick_limit);
              ax_ry <= mmrl_pkg::clamp_axis(item.right_y, regs.joystick_limit);
              state <= ST_MIX;
            end else begin
              if (ms != mmrl_pkg::MS_MAX) ms <= ms + 1'b1;
              state <= ST_TCHK;
            end
          end
        end
        ST_MIX: begin
          raw[0] <= vx16 - vy16 + om16;
          raw[1] <= vx16 + vy16 + om16;
          raw[2] <= vx16 + vy16 - om16;
          raw[3] <= vx16 - vy16 - om16;
          state  <= ST_NORM;
        end
        ST_NORM: begin
          norm    <= norm_c;
          idx     <= '0;
          nonzero <= 1'b0;
          state   <= ST_WMUL;
        end
        ST_WMUL: begin
          prod  <= {15'd0, mag} * {15'd0, regs.speed_limit};
          neg   <= raw[idx][15];
          state <= ST_WSTART;
        end
        ST_WSTART: begin
          state <= ST_WDIV;
        end
        ST_WDIV: begin
          if (div_rsp.done) begin
            goal[idx] <= neg ? -$signed({1'b0, goal_q}) : $signed({1'b0, goal_q});
            if (goal_q != '0) nonzero <= 1'b1;
            if (idx == mmrl_pkg::WHEEL_IDX_W'(mmrl_pkg::WHEELS - 1)) begin
              state <= ST_CDONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_WMUL;
            end
          end
        end
        ST_CDONE: begin
          seen <= 1'b1;
          if (!nonzero) begin
            for (int i = 0; i < mmrl_pkg::WHEELS; i++) ramped[i] <= '0;
            ramp_rem  <= '0;
            stopped_r <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_TCHK: begin
          if (seen && (ms >= {4'd0, regs.control_period_ms})) state <= ST_TMUL;
          else state <= ST_FIN;
        end
        ST_TMUL: begin
          prod  <= {15'd0, regs.speed_limit} * {18'd0, elapsed};
          state <= ST_TSTART;
        end
        ST_TSTART: begin
          state <= ST_TDIV;
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            ramp_rem  <= div_rsp.remainder[11:0];
            ms        <= '0;
            stepped_r <= 1'b1;
            for (int i = 0; i < mmrl_pkg::WHEELS; i++) begin
              ramped[i] <= mmrl_pkg::move_toward(ramped[i], goal[i], step);
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      for (int i = 0; i < mmrl_pkg::WHEELS; i++) res_wheel[i] <= ramped[i];
      res_stepped <= stepped_r;
      res_stopped <= stopped_r;
    end
  end

  assign result.valid   = res_valid;
  assign result.wheel_a = res_wheel[0];
  assign result.wheel_b = res_wheel[1];
  assign result.wheel_c = res_wheel[2];
  assign result.wheel_d = res_wheel[3];
  assign result.stepped = res_stepped;
  assign result.stopped = res_stopped;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the mecanum mixer with ramp limiter: stick commands, ticks, registers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmrl_pkg::*;

  // Item kinds and the unused register slot
  localparam logic                 CMD_STICK = 1'b0;
  localparam logic                 CMD_TICK  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int unsigned MS_SAT       = 4095;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 130;
  localparam int          STEADY_ITEMS = 100;
  localparam int          TAIL_CYCLES  = 200;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] left_x;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } stick_beat_t;

  typedef struct packed {
    wheel_t wheel_a;
    wheel_t wheel_b;
    wheel_t wheel_c;
    wheel_t wheel_d;
    logic   stepped;
    logic   stopped;
  } wheel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmrl_in_if  stick_ch ();
  mmrl_out_if wheel_ch ();
  mmrl_cfg_if reg_ch ();

  mecanum_mixer_ramp_limiter uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (reg_ch),
    .item   (stick_ch),
    .result (wheel_ch)
  );

  always #5ns clk = ~clk;

  // Shadow of the registers and of the ramp state
  cfg_t        shadow_cfg;
  int          goal_pos [WHEELS];
  int          ramp_pos [WHEELS];
  int unsigned ramp_rem;
  bit          cmd_seen;
  int unsigned ms_count;

  wheel_beat_t wheels_due [$];
  int          mismatches = 0;
  bit          gaps_on    = 1'b1;

  function automatic int stick_clip(logic signed [15:0] v);
    int lim;
    lim = int'(shadow_cfg.joystick_limit);
    if (int'(v) > lim) return lim;
    if (int'(v) < -lim) return -lim;
    return int'(v);
  endfunction

  function automatic int slew_toward(int cur, int goal, int step);
    int diff;
    diff = goal - cur;
    if (diff > step) return cur + step;
    if (diff < -step) return cur - step;
    return goal;
  endfunction

  // Next wheel beat for one accepted item; updates the shadow state
  function automatic wheel_beat_t predict_wheels(stick_beat_t b);
    int          lx, rx, ry, vx, vy, w, norm, mag, i;
    int          raw [WHEELS];
    int unsigned rt, elapsed, num, step;
    bit          all_zero;
    wheel_beat_t r;
    r = '0;
    if (b.cmd == CMD_STICK) begin
      lx = stick_clip(b.left_x);
      rx = stick_clip(b.right_x);
      ry = stick_clip(b.right_y);
      vx = ry * int'(shadow_cfg.translation_scale);
      vy = -rx * int'(shadow_cfg.translation_scale);
      w  = lx * int'(shadow_cfg.rotation_scale);
      raw[0] = vx - vy + w;
      raw[1] = vx + vy + w;
      raw[2] = vx + vy - w;
      raw[3] = vx - vy - w;
      // divisor: largest magnitude, never below the axis limit (zero acts as one)
      norm = (shadow_cfg.axis_limit == '0) ? 1 : int'(shadow_cfg.axis_limit);
      for (i = 0; i < WHEELS; i++) begin
        mag = (raw[i] < 0) ? -raw[i] : raw[i];
        if (mag > norm) norm = mag;
      end
      all_zero = 1'b1;
      for (i = 0; i < WHEELS; i++) begin
        goal_pos[i] = int'((longint'(raw[i]) * longint'(int'(shadow_cfg.speed_limit)))
                           / longint'(norm));
        if (goal_pos[i] != 0) all_zero = 1'b0;
      end
      cmd_seen = 1'b1;
      // all-zero goals stop the wheels at once
      if (all_zero) begin
        for (i = 0; i < WHEELS; i++) ramp_pos[i] = 0;
        ramp_rem  = 0;
        r.stopped = 1'b1;
      end
    end else begin
      if (ms_count < MS_SAT) ms_count++;
      if (cmd_seen && ms_count >= shadow_cfg.control_period_ms) begin
        rt       = (shadow_cfg.ramp_time_ms == '0) ? 1 : shadow_cfg.ramp_time_ms;
        elapsed  = (ms_count > rt) ? rt : ms_count;
        num      = ramp_rem + shadow_cfg.speed_limit * elapsed;
        step     = num / rt;
        ramp_rem = num % rt;
        ms_count = 0;
        for (i = 0; i < WHEELS; i++)
          ramp_pos[i] = slew_toward(ramp_pos[i], goal_pos[i], int'(step));
        r.stepped = 1'b1;
      end
    end
    r.wheel_a = wheel_t'(ramp_pos[0]);
    r.wheel_b = wheel_t'(ramp_pos[1]);
    r.wheel_c = wheel_t'(ramp_pos[2]);
    r.wheel_d = wheel_t'(ramp_pos[3]);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] due,
                                      logic signed [31:0] got);
    if (got !== due) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, due, got);
    end
  endfunction

  // Result side: every beat against the oldest prediction
  always @(posedge clk) begin
    wheel_beat_t due;
    if (!rst && wheel_ch.valid && wheel_ch.ready) begin
      if (wheels_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %0d %0d %0d %0d %b %b", $time,
                 wheel_ch.wheel_a, wheel_ch.wheel_b, wheel_ch.wheel_c, wheel_ch.wheel_d,
                 wheel_ch.stepped, wheel_ch.stopped);
      end else begin
        due = wheels_due.pop_front();
        check_field("wheel_a", due.wheel_a, wheel_ch.wheel_a);
        check_field("wheel_b", due.wheel_b, wheel_ch.wheel_b);
        check_field("wheel_c", due.wheel_c, wheel_ch.wheel_c);
        check_field("wheel_d", due.wheel_d, wheel_ch.wheel_d);
        check_field("stepped", due.stepped, wheel_ch.stepped);
        check_field("stopped", due.stopped, wheel_ch.stopped);
      end
    end
  end

  // Result back-pressure: random stall bursts while gaps are on
  initial begin
    int hold;
    hold = 0;
    wheel_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        wheel_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 4);
        wheel_ch.ready <= 1'b0;
      end else begin
        wheel_ch.ready <= 1'b1;
      end
    end
  end

  function automatic stick_beat_t stick(logic signed [15:0] lx, logic signed [15:0] rx,
                                        logic signed [15:0] ry);
    return stick_beat_t'{CMD_STICK, lx, rx, ry};
  endfunction

  // Tick with junk on the unused axis fields
  function automatic stick_beat_t tick_beat();
    return stick_beat_t'{CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic signed [15:0] rand_axis();
    int lim, v;
    lim = int'(shadow_cfg.joystick_limit);
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3: v = int'($signed(16'($urandom)));
      4: begin
        // around the clamp edge
        v = lim + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = int'($urandom_range(0, lim + 8));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return 16'(v);
  endfunction

  function automatic stick_beat_t random_command();
    if ($urandom_range(0, 9) == 0) return stick('0, '0, '0);
    return stick(rand_axis(), rand_axis(), rand_axis());
  endfunction

  function automatic cfg_t pick_config(int kind);
    cfg_t c;
    c.joystick_limit    = 7'($urandom_range(0, 127));
    c.translation_scale = 6'($urandom_range(0, 63));
    c.rotation_scale    = 6'($urandom_range(0, 63));
    c.axis_limit        = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                      : 15'($urandom_range(1, 2000));
    c.speed_limit       = 15'($urandom_range(0, 32767));
    c.ramp_time_ms      = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                      : 12'($urandom_range(1, 64));
    c.control_period_ms = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 12));
    case (kind)
      0: c = cfg_t'{7'd127, 6'd63, 6'd63, 15'd1, 15'd32767, 12'd1, 8'd1};
      1: c = cfg_t'{7'd0, 6'd0, 6'd0, 15'd1, 15'd0, 12'd4095, 8'd255};
      2: begin
        c.axis_limit        = '0;
        c.ramp_time_ms      = '0;
        c.control_period_ms = '0;
      end
      3: c = cfg_t'{7'd127, 6'd63, 6'd0, 15'd32767, 15'd32767, 12'd4095, 8'd1};
      4: c = cfg_t'{7'd127, 6'd0, 6'd63, 15'd0, 15'd32767, 12'd0, 8'd0};
      default: ;
    endcase
    return c;
  endfunction

  // One item: optional idle burst, then hold valid until taken
  task automatic send_item(stick_beat_t b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      stick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stick_ch.valid   <= 1'b1;
    stick_ch.cmd     <= b.cmd;
    stick_ch.left_x  <= b.left_x;
    stick_ch.right_x <= b.right_x;
    stick_ch.right_y <= b.right_y;
    do @(posedge clk); while (!stick_ch.ready);
    wheels_due.push_back(predict_wheels(b));
  endtask

  // Drop valid and let every pending result come out
  task automatic settle();
    stick_ch.valid <= 1'b0;
    while (wheels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers back to back; narrow fields may get junk above their width
  task automatic load_config(cfg_t c, bit with_spare);
    logic [CFG_IDX_W-1:0]  order [8];
    logic [CFG_DATA_W-1:0] val;
    int                    k;
    order = '{REG_JOYSTICK_LIMIT, REG_TRANSLATION_SCALE, REG_ROTATION_SCALE, REG_AXIS_LIMIT,
              REG_SPEED_LIMIT, REG_RAMP_TIME_MS, REG_CONTROL_PERIOD_MS, REG_SPARE};
    for (k = 0; k < (with_spare ? 8 : 7); k++) begin
      val = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) : '0;
      case (order[k])
        REG_JOYSTICK_LIMIT:    val[6:0]  = c.joystick_limit;
        REG_TRANSLATION_SCALE: val[5:0]  = c.translation_scale;
        REG_ROTATION_SCALE:    val[5:0]  = c.rotation_scale;
        REG_AXIS_LIMIT:        val       = c.axis_limit;
        REG_SPEED_LIMIT:       val       = c.speed_limit;
        REG_RAMP_TIME_MS:      val[11:0] = c.ramp_time_ms;
        REG_CONTROL_PERIOD_MS: val[7:0]  = c.control_period_ms;
        default: ;
      endcase
      reg_ch.valid <= 1'b1;
      reg_ch.index <= order[k];
      reg_ch.data  <= val;
      do @(posedge clk); while (!reg_ch.ready);
    end
    reg_ch.valid <= 1'b0;
    shadow_cfg = c;
  endtask

  // Commands each followed by a run of ticks, with some lone items as noise
  task automatic run_sequences(int count);
    int sent, run, span;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(($urandom_range(0, 1) == 1) ? tick_beat() : random_command());
        sent++;
      end else begin
        send_item(random_command());
        sent++;
        span = 3 * int'(shadow_cfg.control_period_ms) + 3;
        if (span > 40 && $urandom_range(0, 7) != 0) span = 40;
        run = $urandom_range(1, span);
        if (run > count - sent) run = (count > sent) ? count - sent : 1;
        repeat (run) send_item(tick_beat());
        sent += run;
      end
    end
  endtask

  task automatic test_idle_ticks();
    // no command yet: time counts, the ramp stays put
    repeat (2) send_item(tick_beat());
  endtask

  task automatic test_stick_extremes();
    send_item(stick('0, '0, '0));
    send_item(stick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    send_item(stick(16'sh8000, 16'sh8000, 16'sh8000));
    send_item(stick(16'sh8000, '0, '0));
    send_item(stick('0, 16'sd101, '0));
    send_item(stick('0, '0, -16'sd100));
    // one full control period gives the first ramp step
    repeat (int'(RST_CONTROL_PERIOD_MS)) send_item(tick_beat());
  endtask

  task automatic test_zero_registers();
    // zero axis limit and ramp time act as one; zero period steps on every tick
    settle();
    load_config(cfg_t'{7'd127, 6'd1, 6'd0, 15'd0, 15'd2, 12'd0, 8'd0}, 1'b1);
    send_item(stick('0, '0, 16'sd1));
    send_item(tick_beat());
    send_item(tick_beat());
  endtask

  task automatic test_stale_remainder();
    // build a large remainder, then shrink the ramp time below it
    settle();
    load_config(cfg_t'{7'd127, 6'd63, 6'd0, 15'd1, 15'd4094, 12'd4095, 8'd1}, 1'b0);
    send_item(stick('0, '0, 16'sd127));
    send_item(tick_beat());
    settle();
    load_config(cfg_t'{7'd127, 6'd63, 6'd0, 15'd1, 15'd4094, 12'd5, 8'd1}, 1'b0);
    send_item(tick_beat());
    send_item(tick_beat());
  endtask

  task automatic test_random_phases();
    int p;
    for (p = 0; p < PHASES; p++) begin
      settle();
      gaps_on = (p % 5 != 3);
      load_config(pick_config(p), p == 2);
      run_sequences(PHASE_ITEMS);
    end
  endtask

  task automatic test_steady_stream();
    settle();
    gaps_on = 1'b0;
    load_config(pick_config(PHASES), 1'b0);
    run_sequences(STEADY_ITEMS);
  endtask

  // Stimulus and final verdict
  initial begin
    stick_ch.valid   <= 1'b0;
    stick_ch.cmd     <= CMD_TICK;
    stick_ch.left_x  <= '0;
    stick_ch.right_x <= '0;
    stick_ch.right_y <= '0;
    reg_ch.valid     <= 1'b0;
    reg_ch.index     <= REG_JOYSTICK_LIMIT;
    reg_ch.data      <= '0;
    shadow_cfg = cfg_t'{RST_JOYSTICK_LIMIT, RST_TRANSLATION_SCALE, RST_ROTATION_SCALE,
                        RST_AXIS_LIMIT, RST_SPEED_LIMIT, RST_RAMP_TIME_MS,
                        RST_CONTROL_PERIOD_MS};
    for (int i = 0; i < WHEELS; i++) begin
      goal_pos[i] = 0;
      ramp_pos[i] = 0;
    end
    ramp_rem = 0;
    cmd_seen = 1'b0;
    ms_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_ticks();
    test_stick_extremes();
    test_zero_registers();
    test_stale_remainder();
    test_random_phases();
    test_steady_stream();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && wheels_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
